### hw/rtl/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

    // item widths
    localparam int ANGLE_W = 32;
    localparam int COS_W   = 32;

    // internal fixed point: unsigned magnitudes with 56 fraction bits
    localparam int ACC_W  = 64;
    localparam int FRAC_W = 56;
    localparam int HALF_W = 32;
    localparam int R_W    = 59;   // reduced angle stays below 2*pi
    localparam int X2_W   = 62;   // square of the reduced angle stays below 64
    localparam int FAC_W  = 62;   // step factor x2/d
    localparam int RCP_W  = X2_W + 1;
    localparam int QBITS  = 5;    // whole turns in 2^7 radians fit in 5 bits

    localparam logic [ACC_W-1:0] TWO_PI_Q56 = 64'h06487ED5110B4612;
    localparam logic [ACC_W-1:0] ONE_Q56    = 64'h0100000000000000;
    localparam logic [ACC_W-1:0] HALF_LSB   = 64'h0000000001000000;
    localparam int               RQ_W       = 31;
    localparam logic [RQ_W-1:0]  ONE_Q30    = 31'h40000000;
    localparam int               RQ_SHIFT   = 25;

    // state handed from one series cell to the next
    typedef struct packed {
        logic [X2_W-1:0]  x2;
        logic [ACC_W-1:0] term;
        logic [ACC_W-1:0] sum;
    } cts_link_t;

endpackage

### hw/rtl/cts_reduce_cell.sv
`timescale 1ns / 1ps

module cts_reduce_cell
    import cts_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [ACC_W-1:0] in_r,
    output logic             out_valid,
    output logic [ACC_W-1:0] out_r
);

    localparam logic [ACC_W-1:0] STEP = TWO_PI_Q56 << SHIFT;

    logic             v_reg;
    logic [ACC_W-1:0] r_reg;
    logic [ACC_W-1:0] r_next;

    // one restoring step of the reduction by 2*pi
    always_comb
    begin
        if (in_r >= STEP)
        begin
            r_next = in_r - STEP;
        end
        else
        begin
            r_next = in_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign out_valid = v_reg;
    assign out_r     = r_reg;

endmodule

### hw/rtl/cts_square.sv
`timescale 1ns / 1ps

module cts_square
    import cts_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [R_W-1:0]  in_r,
    output logic            out_valid,
    output logic [X2_W-1:0] out_x2
);

    localparam int RH_W = R_W - HALF_W;
    localparam int SQ_W = 2 * R_W;

    logic [HALF_W-1:0]        rl;
    logic [RH_W-1:0]          rh;
    logic                     va_reg;
    logic                     vb_reg;
    logic [2*HALF_W-1:0]      p_ll_reg;
    logic [HALF_W+RH_W-1:0]   p_lh_reg;
    logic [2*RH_W-1:0]        p_hh_reg;
    logic [2*HALF_W-1:0]      p_ll_next;
    logic [HALF_W+RH_W-1:0]   p_lh_next;
    logic [2*RH_W-1:0]        p_hh_next;
    logic [SQ_W-1:0]          sq;
    logic [X2_W-1:0]          x2_reg;
    logic [X2_W-1:0]          x2_next;

    assign rl = in_r[HALF_W-1:0];
    assign rh = in_r[R_W-1:HALF_W];

    // partial products, the cross term is doubled by its shift
    always_comb
    begin
        p_ll_next = (2*HALF_W)'(rl) * (2*HALF_W)'(rl);
        p_lh_next = (HALF_W+RH_W)'(rl) * (HALF_W+RH_W)'(rh);
        p_hh_next = (2*RH_W)'(rh) * (2*RH_W)'(rh);
    end

    // sum of partials, keep the q56 part
    always_comb
    begin
        sq = (SQ_W'(p_hh_reg) << (2*HALF_W)) + (SQ_W'(p_lh_reg) << (HALF_W+1))
             + SQ_W'(p_ll_reg);
        x2_next = sq[FRAC_W +: X2_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ll_reg <= p_ll_next;
        p_lh_reg <= p_lh_next;
        p_hh_reg <= p_hh_next;
        x2_reg   <= x2_next;
    end

    assign out_valid = vb_reg;
    assign out_x2    = x2_reg;

endmodule

### hw/rtl/cts_term_cell.sv
`timescale 1ns / 1ps

module cts_term_cell
    import cts_pkg::*;
#(
    parameter int IDX = 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  cts_link_t in_link,
    output logic      out_valid,
    output cts_link_t out_link
);

    // divisor (2i-1)(2i) turned into a rounded-up reciprocal, exact for 62-bit x2
    localparam int  DIV_K    = (2*IDX - 1) * (2*IDX);
    localparam int  SH       = X2_W + $clog2(DIV_K);
    localparam int  PW       = X2_W + RCP_W;
    localparam logic [PW-1:0] POW    = PW'(1) << SH;
    localparam logic [PW-1:0] DIVR   = PW'(DIV_K);
    localparam logic [PW-1:0] RCP_WD = (POW + DIVR - PW'(1)) / DIVR;
    localparam logic [RCP_W-1:0] RCP = RCP_WD[RCP_W-1:0];
    localparam bit  SUB_PREV = ((IDX - 1) % 2) == 1;

    localparam int XH_W = X2_W - HALF_W;
    localparam int MH_W = RCP_W - HALF_W;
    localparam int FH_W = FAC_W - HALF_W;
    localparam int QW   = ACC_W + FAC_W;

    localparam logic [HALF_W-1:0] ML = RCP[HALF_W-1:0];
    localparam logic [MH_W-1:0]   MH = RCP[RCP_W-1:HALF_W];

    logic                      va_reg;
    logic                      vb_reg;
    logic                      vc_reg;
    logic                      vd_reg;
    cts_link_t                 la_reg;
    cts_link_t                 lb_reg;
    cts_link_t                 lc_reg;
    cts_link_t                 ld_reg;
    cts_link_t                 la_next;
    cts_link_t                 ld_next;

    logic [2*HALF_W-1:0]       pa_ll_reg;
    logic [HALF_W+MH_W-1:0]    pa_lh_reg;
    logic [XH_W+HALF_W-1:0]    pa_hl_reg;
    logic [XH_W+MH_W-1:0]      pa_hh_reg;
    logic [2*HALF_W-1:0]       pa_ll_next;
    logic [HALF_W+MH_W-1:0]    pa_lh_next;
    logic [XH_W+HALF_W-1:0]    pa_hl_next;
    logic [XH_W+MH_W-1:0]      pa_hh_next;

    logic [PW-1:0]             fprod;
    logic [FAC_W-1:0]          fac_reg;
    logic [FAC_W-1:0]          fac_next;

    logic [2*HALF_W-1:0]       pc_ll_reg;
    logic [HALF_W+FH_W-1:0]    pc_lh_reg;
    logic [2*HALF_W-1:0]       pc_hl_reg;
    logic [HALF_W+FH_W-1:0]    pc_hh_reg;
    logic [2*HALF_W-1:0]       pc_ll_next;
    logic [HALF_W+FH_W-1:0]    pc_lh_next;
    logic [2*HALF_W-1:0]       pc_hl_next;
    logic [HALF_W+FH_W-1:0]    pc_hh_next;
    logic [QW-1:0]             tprod;

    logic [HALF_W-1:0]         xl;
    logic [XH_W-1:0]           xh;
    logic [HALF_W-1:0]         tl;
    logic [HALF_W-1:0]         th;
    logic [HALF_W-1:0]         fl;
    logic [FH_W-1:0]           fh;

    assign xl = in_link.x2[HALF_W-1:0];
    assign xh = in_link.x2[X2_W-1:HALF_W];
    assign tl = lb_reg.term[HALF_W-1:0];
    assign th = lb_reg.term[ACC_W-1:HALF_W];
    assign fl = fac_reg[HALF_W-1:0];
    assign fh = fac_reg[FAC_W-1:HALF_W];

    // stage a: fold in the previous term, partials of x2 times the reciprocal
    always_comb
    begin
        la_next = in_link;
        if (SUB_PREV)
        begin
            la_next.sum = in_link.sum - in_link.term;
        end
        else
        begin
            la_next.sum = in_link.sum + in_link.term;
        end
        pa_ll_next = (2*HALF_W)'(xl) * (2*HALF_W)'(ML);
        pa_lh_next = (HALF_W+MH_W)'(xl) * (HALF_W+MH_W)'(MH);
        pa_hl_next = (XH_W+HALF_W)'(xh) * (XH_W+HALF_W)'(ML);
        pa_hh_next = (XH_W+MH_W)'(xh) * (XH_W+MH_W)'(MH);
    end

    // stage b: step factor x2/d
    always_comb
    begin
        fprod = (PW'(pa_hh_reg) << (2*HALF_W)) + (PW'(pa_lh_reg) << HALF_W)
                + (PW'(pa_hl_reg) << HALF_W) + PW'(pa_ll_reg);
        fac_next = FAC_W'(fprod >> SH);
    end

    // stage c: partials of term times factor
    always_comb
    begin
        pc_ll_next = (2*HALF_W)'(tl) * (2*HALF_W)'(fl);
        pc_lh_next = (HALF_W+FH_W)'(tl) * (HALF_W+FH_W)'(fh);
        pc_hl_next = (2*HALF_W)'(th) * (2*HALF_W)'(fl);
        pc_hh_next = (HALF_W+FH_W)'(th) * (HALF_W+FH_W)'(fh);
    end

    // stage d: new term, truncated q56
    always_comb
    begin
        tprod = (QW'(pc_hh_reg) << (2*HALF_W)) + (QW'(pc_lh_reg) << HALF_W)
                + (QW'(pc_hl_reg) << HALF_W) + QW'(pc_ll_reg);
        ld_next      = lc_reg;
        ld_next.term = tprod[FRAC_W +: ACC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg    <= la_next;
        pa_ll_reg <= pa_ll_next;
        pa_lh_reg <= pa_lh_next;
        pa_hl_reg <= pa_hl_next;
        pa_hh_reg <= pa_hh_next;
        lb_reg    <= la_reg;
        fac_reg   <= fac_next;
        lc_reg    <= lb_reg;
        pc_ll_reg <= pc_ll_next;
        pc_lh_reg <= pc_lh_next;
        pc_hl_reg <= pc_hl_next;
        pc_hh_reg <= pc_hh_next;
        ld_reg    <= ld_next;
    end

    assign out_valid = vd_reg;
    assign out_link  = ld_reg;

endmodule

### hw/rtl/cts_round.sv
`timescale 1ns / 1ps

module cts_round
    import cts_pkg::*;
#(
    parameter int LAST_IDX = 17
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  cts_link_t               in_link,
    output logic                    done,
    output logic signed [COS_W-1:0] cosine
);

    localparam bit SUB_LAST = (LAST_IDX % 2) == 1;
    localparam int RT_W     = ACC_W - RQ_SHIFT;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    v4_reg;
    logic [ACC_W-1:0]        sum_reg;
    logic [ACC_W-1:0]        sum_next;
    logic                    neg_reg;
    logic                    neg3_reg;
    logic [ACC_W-1:0]        smag_reg;
    logic [ACC_W-1:0]        smag_next;
    logic [ACC_W-1:0]        rsum;
    logic [RQ_W-1:0]         rq_reg;
    logic [RQ_W-1:0]         rq_next;
    logic signed [COS_W-1:0] cos_reg;
    logic signed [COS_W-1:0] cos_next;

    // last term of the series
    always_comb
    begin
        if (SUB_LAST)
        begin
            sum_next = in_link.sum - in_link.term;
        end
        else
        begin
            sum_next = in_link.sum + in_link.term;
        end
    end

    // magnitude of the sum
    always_comb
    begin
        if (sum_reg[ACC_W-1])
        begin
            smag_next = ACC_W'(0) - sum_reg;
        end
        else
        begin
            smag_next = sum_reg;
        end
    end

    // round half away from zero to q30, limit to one
    always_comb
    begin
        rsum = (smag_reg >> 1) + HALF_LSB;
        if (rsum[ACC_W-1:RQ_SHIFT] > RT_W'(ONE_Q30))
        begin
            rq_next = ONE_Q30;
        end
        else
        begin
            rq_next = rsum[RQ_SHIFT +: RQ_W];
        end
    end

    // sign back on
    always_comb
    begin
        if (neg3_reg)
        begin
            cos_next = COS_W'(0) - COS_W'(rq_reg);
        end
        else
        begin
            cos_next = COS_W'(rq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        neg_reg  <= sum_reg[ACC_W-1];
        smag_reg <= smag_next;
        neg3_reg <= neg_reg;
        rq_reg   <= rq_next;
        cos_reg  <= cos_next;
    end

    assign done   = v4_reg;
    assign cosine = cos_reg;

endmodule

### hw/rtl/cosine_taylor_series.sv
`timescale 1ns / 1ps

// Cosine of a signed Q8.24 angle in radians, result signed Q2.30 limited to +/-1.
// Command channel: an item is taken at a rising edge with start high and busy
// low. busy is always low, so a new angle may be given in every cycle.
// Result channel: cosine is valid for exactly one cycle while done is high;
// results come out in the order the angles went in and cannot be held off.
// Throughput is one item per cycle.
// The path is a register chain: an input stage, five restoring stages that
// strip whole turns of 2*pi, a two stage square, then one cell of four stages
// for each series term after the leading one, each multiplying by a constant
// reciprocal and then by the running term, and four stages of final sum,
// rounding and limiting.
// Reset clears only the valid bits of the chain; items in flight are dropped
// and no done follows until a new angle is taken.
module cosine_taylor_series
    import cts_pkg::*;
#(
    parameter int TERMS = 18
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                    done,
    output logic signed [COS_W-1:0] cosine
);

    logic                   accept;
    logic                   v0_reg;
    logic [ACC_W-1:0]       m0_reg;
    logic [ACC_W-1:0]       m0_next;
    logic [ANGLE_W-1:0]     mag;

    logic [QBITS:0]         rv;
    logic [ACC_W-1:0]       rr [QBITS+1];

    logic                   sq_valid;
    logic [X2_W-1:0]        x2;

    logic [TERMS-1:0]       lv;
    cts_link_t              link [TERMS];

    // the chain never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // magnitude of the angle, moved to q56
    always_comb
    begin
        if (angle[ANGLE_W-1])
        begin
            mag = $unsigned(-angle);
        end
        else
        begin
            mag = $unsigned(angle);
        end
        m0_next = {mag, {(ACC_W-ANGLE_W){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg <= m0_next;
    end

    // reduction modulo 2*pi, largest multiple first
    assign rv[0] = v0_reg;
    assign rr[0] = m0_reg;

    for (genvar j = 0; j < QBITS; j++)
    begin : g_reduce
        cts_reduce_cell #(
            .SHIFT (QBITS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rv[j]),
            .in_r      (rr[j]),
            .out_valid (rv[j+1]),
            .out_r     (rr[j+1])
        );
    end

    // square of the reduced angle
    cts_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rv[QBITS]),
        .in_r      (rr[QBITS][R_W-1:0]),
        .out_valid (sq_valid),
        .out_x2    (x2)
    );

    // series cells, leading one rides in as the first term
    assign lv[0]        = sq_valid;
    assign link[0].x2   = x2;
    assign link[0].term = ONE_Q56;
    assign link[0].sum  = '0;

    for (genvar k = 1; k < TERMS; k++)
    begin : g_term
        cts_term_cell #(
            .IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lv[k-1]),
            .in_link   (link[k-1]),
            .out_valid (lv[k]),
            .out_link  (link[k])
        );
    end

    // last term, rounding and limiting
    cts_round #(
        .LAST_IDX (TERMS - 1)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lv[TERMS-1]),
        .in_link  (link[TERMS-1]),
        .done     (done),
        .cosine   (cosine)
    );

endmodule
